// ----- hdl/tlc_pkg.sv -----
package tlc_pkg;

  typedef struct packed {
    logic [15:0] broadband_count;
    logic [15:0] infrared_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] lux_value;
    logic        saturated;
  } out_item_t;

  localparam int unsigned DEF_POWER_TABLE_ENTRIES = 64;

  localparam logic [1:0] REG_HIGH_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_SEL  = 2'd1;
  localparam logic [1:0] REG_CS_PACKAGE = 2'd2;

  localparam logic [1:0] INTEG_13MS  = 2'd0;
  localparam logic [1:0] INTEG_100MS = 2'd1;
  localparam logic [1:0] INTEG_402MS = 2'd2;
  localparam logic [1:0] INTEG_SPARE = 2'd3;

  localparam logic [2:0] SEG_POW  = 3'd0;
  localparam logic [2:0] SEG_L1   = 3'd1;
  localparam logic [2:0] SEG_L2   = 3'd2;
  localparam logic [2:0] SEG_L3   = 3'd3;
  localparam logic [2:0] SEG_ZERO = 3'd4;

  localparam logic [15:0] FULL_SCALE = 16'hFFFF;

  localparam logic [20:0] SCALE_13MS  = 21'd1923027;
  localparam logic [20:0] SCALE_100MS = 21'd263455;
  localparam logic [20:0] SCALE_402MS = 21'd65536;

  // pipeline payload
  typedef struct packed {
    logic                sat;
    logic [2:0]          seg;
    logic [15:0]         c0;
    logic [15:0]         c1;
    logic [19:0]         pa;
    logic [19:0]         pb;
    logic [18:0]         la;
    logic [18:0]         lb;
    logic [16:0]         rem;
    logic [15:0]         quo;
    logic [15:0]         frac;
    logic [16:0]         tab_a;
    logic [16:0]         tab_d;
    logic [32:0]         interp;
    logic [16:0]         pw;
    logic [36:0]         term;
    logic signed [21:0]  pdiff;
    logic [34:0]         lin_ac;
    logic [34:0]         lin_bc;
    logic signed [35:0]  lin_diff;
    logic signed [37:0]  inner_pow;
    logic [35:0]         inner;
    logic [24:0]         scale;
    logic [42:0]         plo;
    logic [42:0]         phi;
  } pl_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] quo;
  } div_t;

  // four restoring division steps
  function automatic div_t div_step4(input logic [16:0] rem, input logic [15:0] quo,
                                     input logic [15:0] c0);
    div_t r;
    r.rem = rem;
    r.quo = quo;
    for (int k = 0; k < 4; k++) begin
      r.rem = {r.rem[15:0], 1'b0};
      r.quo = {r.quo[14:0], 1'b0};
      if (r.rem >= {1'b0, c0}) begin
        r.rem = r.rem - {1'b0, c0};
        r.quo[0] = 1'b1;
      end
    end
    return r;
  endfunction

  // r^1.4 table point, x in q0.30, result q0.16
  function automatic logic [16:0] pow_entry(input longint unsigned x);
    longint unsigned sq;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned m;
    longint unsigned e;
    sq = (x * x) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      m = mid;
      for (int k = 0; k < 4; k++) m = (m * mid) >> 30;
      if (m <= sq) lo = mid;
      else hi = mid - 1;
    end
    e = (((x * lo) >> 30) + 64'd8192) >> 14;
    return e[16:0];
  endfunction

endpackage

// ----- hdl/two_channel_lux_calculator_top.sv -----
// each accepted input item is registered through s1 to s15 and then out_item
// throughput: one item per cycle, whole pipeline holds while the output is stalled
// reset: synchronous rst clears all valid bits and sets high_gain 0,
// integration_select 2, cs_package 0; the power table is constant logic
module two_channel_lux_calculator_top #(
  parameter int unsigned POWER_TABLE_ENTRIES = tlc_pkg::DEF_POWER_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tlc_pkg::out_item_t out_item,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data
);
  import tlc_pkg::*;

  localparam int IDX_W = $clog2(POWER_TABLE_ENTRIES + 1);
  localparam int POS_W = 16 + IDX_W;

  logic       high_gain;
  logic [1:0] integration_select;
  logic       cs_package;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_gain          <= 1'b0;
      integration_select <= INTEG_402MS;
      cs_package         <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HIGH_GAIN:  high_gain          <= cfg_data[0];
        REG_INTEG_SEL:  integration_select <= cfg_data;
        REG_CS_PACKAGE: cs_package         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [16:0] ptab [POWER_TABLE_ENTRIES + 1];
  for (genvar i = 0; i <= POWER_TABLE_ENTRIES; i++) begin : g_tab
    localparam longint unsigned X = (64'(i) << 30) / POWER_TABLE_ENTRIES;
    assign ptab[i] = pow_entry(X);
  end

  logic en;
  logic [15:0] v;
  pl_t s1, s2, s3, s4, s5, s6, s7, s8, s9, s10, s11, s12, s13, s14, s15;
  logic [IDX_W-1:0] idx6;
  out_item_t res;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[14:0], in_valid};
  end
  assign out_valid = v[15];

  // stage 1: segment and coefficients
  pl_t         st1;
  logic [23:0] m100;
  always_comb begin
    st1 = '0;
    st1.c0 = in_item.broadband_count;
    st1.c1 = in_item.infrared_count;
    st1.sat = (st1.c0 == FULL_SCALE) || (st1.c1 == FULL_SCALE);
    m100 = 24'(st1.c1) * 24'd100;
    if (m100 < 24'(st1.c0) * (cs_package ? 24'd52 : 24'd50)) st1.seg = SEG_POW;
    else if (m100 < 24'(st1.c0) * (cs_package ? 24'd65 : 24'd61)) st1.seg = SEG_L1;
    else if (m100 < 24'(st1.c0) * 24'd80) st1.seg = SEG_L2;
    else if (m100 < 24'(st1.c0) * 24'd130) st1.seg = SEG_L3;
    else st1.seg = SEG_ZERO;
    st1.pa = cs_package ? 20'd528482 : 20'd510027;
    st1.pb = cs_package ? 20'd994889 : 20'd1040187;
    case (st1.seg)
      SEG_L1: begin
        st1.la = cs_package ? 19'd384198 : 19'd375810;
        st1.lb = cs_package ? 19'd488217 : 19'd520094;
      end
      SEG_L2: begin
        st1.la = cs_package ? 19'd263402 : 19'd214748;
        st1.lb = 19'd256691;
      end
      SEG_L3: begin
        st1.la = cs_package ? 19'd56707 : 19'd24495;
        st1.lb = cs_package ? 19'd43621 : 19'd18790;
      end
      default: begin
        st1.la = '0;
        st1.lb = '0;
      end
    endcase
    st1.rem = (st1.seg == SEG_POW) ? {1'b0, st1.c1} : 17'd0;
  end

  div_t d2, d3, d4, d5;
  assign d2 = div_step4(s1.rem, s1.quo, s1.c0);
  assign d3 = div_step4(s2.rem, s2.quo, s2.c0);
  assign d4 = div_step4(s3.rem, s3.quo, s3.c0);
  assign d5 = div_step4(s4.rem, s4.quo, s4.c0);

  logic [POS_W-1:0] pos;
  assign pos = POS_W'(s5.quo) * POS_W'(POWER_TABLE_ENTRIES);

  logic [35:0] inner_sel;
  logic [24:0] scale_sel;
  always_comb begin
    case (s12.seg)
      SEG_POW:          inner_sel = s12.inner_pow < 0 ? 36'd0 : s12.inner_pow[35:0];
      SEG_L1, SEG_L2, SEG_L3: inner_sel = s12.lin_diff < 0 ? 36'd0 : s12.lin_diff[35:0];
      default:          inner_sel = 36'd0;
    endcase
    case (integration_select)
      INTEG_13MS:  scale_sel = 25'(SCALE_13MS);
      INTEG_100MS: scale_sel = 25'(SCALE_100MS);
      default:     scale_sel = 25'(SCALE_402MS);
    endcase
    if (!high_gain) scale_sel = scale_sel << 4;
  end

  logic [61:0] full;
  logic [33:0] lux_w;
  always_comb begin
    full  = (62'(s15.phi) << 18) + 62'(s15.plo) + (62'd1 << 27);
    lux_w = full[61:28];
    res.saturated = s15.sat;
    if (s15.sat) res.lux_value = '0;
    else if (lux_w[33:32] != 2'b00) res.lux_value = 32'hFFFF_FFFF;
    else res.lux_value = lux_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= st1;
      s2 <= s1;
      s2.rem <= d2.rem;
      s2.quo <= d2.quo;
      s2.lin_ac <= 35'(s1.la) * 35'(s1.c0);
      s2.lin_bc <= 35'(s1.lb) * 35'(s1.c1);
      s3 <= s2;
      s3.rem <= d3.rem;
      s3.quo <= d3.quo;
      s3.lin_diff <= $signed({1'b0, s2.lin_ac}) - $signed({1'b0, s2.lin_bc});
      s4 <= s3;
      s4.rem <= d4.rem;
      s4.quo <= d4.quo;
      s5 <= s4;
      s5.rem <= d5.rem;
      s5.quo <= d5.quo;
      s6 <= s5;
      s6.frac <= pos[15:0];
      idx6 <= pos[POS_W-1:16];
      s7 <= s6;
      s7.tab_a <= ptab[idx6];
      s7.tab_d <= ptab[idx6 + IDX_W'(1)] - ptab[idx6];
      s8 <= s7;
      s8.interp <= 33'(s7.tab_d) * 33'(s7.frac);
      s9 <= s8;
      s9.pw <= s8.tab_a + s8.interp[32:16];
      s10 <= s9;
      s10.term <= 37'(s9.pb) * 37'(s9.pw) + 37'd32768;
      s11 <= s10;
      s11.pdiff <= $signed({2'b00, s10.pa}) - $signed({1'b0, s10.term[36:16]});
      s12 <= s11;
      s12.inner_pow <= $signed({22'd0, s11.c0}) * 38'(s11.pdiff);
      s13 <= s12;
      s13.inner <= inner_sel;
      s13.scale <= scale_sel;
      s14 <= s13;
      s14.plo <= 43'(s13.inner[17:0]) * 43'(s13.scale);
      s15 <= s14;
      s15.phi <= 43'(s14.inner[35:18]) * 43'(s14.scale);
      out_item <= res;
    end
  end

endmodule

// ----- hdl/tlc_checker.sv -----
module tlc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tlc_pkg::out_item_t out_item
);
  import tlc_pkg::*;

  // saturated item carries zero lux
  a_sat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.saturated |-> out_item.lux_value == 32'd0)
    else $error("saturated item with nonzero lux");

  // input held back only by a stalled result
  a_in_stall: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled item changed");

endmodule

bind two_channel_lux_calculator_top tlc_checker u_tlc_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
